// ----- rtl/core/dense_unique_set_swap_remove_defines.svh -----
// Assertion macros for the dense unique set block.
// Used by the top level; depends on clk and rst_n being in scope.
`ifndef DENSE_UNIQUE_SET_SWAP_REMOVE_DEFINES_SVH
`define DENSE_UNIQUE_SET_SWAP_REMOVE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DUSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DUSR_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);
`else
`define DUSR_ASSERT(lbl, prop, msg)
`define DUSR_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif
`endif

// ----- rtl/core/dusr_pkg.sv -----
// Shared types and codes for the dense unique set block.
// No dependencies; imported by the interfaces, the slot cell and the top level.
package dusr_pkg;

    localparam int KEY_IN_W   = 32;
    localparam int IDX_W      = 5;
    localparam int TYPE_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 6;
    localparam int VALUE_W    = 32;

    localparam logic [TYPE_W-1:0] REQ_INSERT    = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_ERASE_KEY = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_ERASE_IDX = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_FIND      = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_READ      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    // Per-slot control from the sequencer to one cell.
    typedef struct packed {
        logic cmp_en;
        logic wr_en;
    } cell_ctl_t;

endpackage

// ----- rtl/core/dusr_chan_if.sv -----
// Request and response channel interfaces with valid/ready handshake.
// Depends on dusr_pkg for field widths.
interface dusr_req_if import dusr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TYPE_W-1:0]   req_type;
    logic [KEY_IN_W-1:0] key;
    logic [IDX_W-1:0]    slot_index;

    modport source (output valid, req_type, key, slot_index, input ready);
    modport sink   (input valid, req_type, key, slot_index, output ready);
endinterface

interface dusr_rsp_if import dusr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] found_slot;
    logic [SLOT_OUT_W-1:0] entry_count;
    logic [VALUE_W-1:0]    entry_value;

    modport source (output valid, status, hit, found_slot, entry_count, entry_value,
                    input ready);
    modport sink   (input valid, status, hit, found_slot, entry_count, entry_value,
                    output ready);
endinterface

// ----- rtl/core/dense_unique_set_swap_remove.sv -----
// Dense unique set with swap-remove, built as a row of slot cells.
// A request is taken in the idle state, where all cells compare against its key;
// the execute state then writes back and loads the response register once it is free.
// Reset clears the count and the handshake state; slot contents are not cleared.
// A request is taken only when the sequencer is idle; the response register
// lets the next request in while an earlier response still waits.
`include "dense_unique_set_swap_remove_defines.svh"

module dense_unique_set_swap_remove import dusr_pkg::*; #(
    parameter int CAPACITY  = 32,
    parameter int KEY_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    dusr_req_if.sink   req,
    dusr_rsp_if.source rsp
);

    // Count width holds CAPACITY itself; MW is a common width for slot arithmetic
    // that also covers the five-bit index and the six-bit slot output.
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int MW  = (CW > SLOT_OUT_W) ? CW : SLOT_OUT_W;
    localparam int EXW = (KEY_WIDTH > KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;

    // Request captured at the accepting edge.
    logic [TYPE_W-1:0]    type_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [KEY_WIDTH-1:0] rd_val_reg;
    logic [KEY_WIDTH-1:0] top_val_reg;

    // Response register.
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  hit_reg, hit_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic [SLOT_OUT_W-1:0] cnt_out_reg, cnt_out_next;
    logic [VALUE_W-1:0]    value_reg, value_next;

    logic                 accept;
    logic                 exec_done;
    logic [KEY_WIDTH-1:0] key_in;
    logic [EXW-1:0]       key_ext;
    logic [MW-1:0]        idx_in_ext;
    logic [MW-1:0]        count_ext;
    logic [MW-1:0]        top_idx;

    logic [KEY_WIDTH-1:0] ent [CAPACITY];
    logic [CAPACITY-1:0]  hit_vec;
    cell_ctl_t            ctl [CAPACITY];

    logic [KEY_WIDTH-1:0] rd_sel;
    logic [KEY_WIDTH-1:0] top_sel;
    logic                 hit_any;
    logic [MW-1:0]        hit_slot;
    logic [MW-1:0]        idx_ext;
    logic                 idx_ok;
    logic                 wr_req;
    logic                 wr_fire;
    logic [MW-1:0]        wr_slot;
    logic [KEY_WIDTH-1:0] wr_data;
    logic [EXW-1:0]       rd_ext;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign exec_done = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    // Only the low KEY_WIDTH bits of the key take part; a narrower key is zero-extended.
    assign key_ext    = EXW'(req.key);
    assign key_in     = key_ext[KEY_WIDTH-1:0];
    assign idx_in_ext = MW'(req.slot_index);
    assign count_ext  = MW'(count_reg);
    assign top_idx    = count_ext - MW'(1);
    assign idx_ext    = MW'(idx_reg);
    assign idx_ok     = (idx_ext < count_ext);

    // The row of slot cells. Every cell compares at the accepting edge and
    // writes at most once at the edge that completes the request.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_slot
        assign ctl[g].cmp_en = accept;
        assign ctl[g].wr_en  = wr_fire && (wr_slot == MW'(g));

        dusr_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CW),
            .INDEX     (g)
        ) u_slot (
            .clk     (clk),
            .ctl     (ctl[g]),
            .count   (count_reg),
            .cmp_key (key_in),
            .wr_data (wr_data),
            .entry   (ent[g]),
            .match   (hit_vec[g])
        );
    end

    // Slot selection for reads and for the top entry used by swap-remove.
    always_comb
    begin
        rd_sel  = '0;
        top_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (MW'(i) == idx_in_ext)
            begin
                rd_sel = rd_sel | ent[i];
            end
            if (MW'(i) == top_idx)
            begin
                top_sel = top_sel | ent[i];
            end
        end
    end

    // Keys in the set are unique, so at most one cell matches and the
    // matching slot is the OR of the indices of the matching cells.
    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hit_vec[i])
            begin
                hit_slot = hit_slot | MW'(i);
            end
        end
    end
    assign hit_any = |hit_vec;

    assign rd_ext = EXW'(rd_val_reg);

    // Decision and write-back for the request in flight.
    always_comb
    begin
        status_next  = ST_OK;
        hit_next     = 1'b0;
        slot_next    = count_ext[SLOT_OUT_W-1:0];
        value_next   = '0;
        count_next   = count_reg;
        wr_req       = 1'b0;
        wr_slot      = count_ext;
        wr_data      = key_reg;
        unique case (type_reg)
            REQ_INSERT:
            begin
                if (hit_any)
                begin
                    status_next = ST_PRESENT;
                    hit_next    = 1'b1;
                    slot_next   = hit_slot[SLOT_OUT_W-1:0];
                end
                else if (count_ext == MW'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_req     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            REQ_ERASE_KEY:
            begin
                if (hit_any)
                begin
                    hit_next   = 1'b1;
                    slot_next  = hit_slot[SLOT_OUT_W-1:0];
                    wr_req     = (hit_slot != top_idx);
                    wr_slot    = hit_slot;
                    wr_data    = top_val_reg;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            REQ_ERASE_IDX:
            begin
                if (idx_ok)
                begin
                    slot_next  = idx_ext[SLOT_OUT_W-1:0];
                    wr_req     = (idx_ext != top_idx);
                    wr_slot    = idx_ext;
                    wr_data    = top_val_reg;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            REQ_FIND:
            begin
                if (hit_any)
                begin
                    hit_next  = 1'b1;
                    slot_next = hit_slot[SLOT_OUT_W-1:0];
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            REQ_READ:
            begin
                if (idx_ok)
                begin
                    slot_next  = idx_ext[SLOT_OUT_W-1:0];
                    value_next = rd_ext[VALUE_W-1:0];
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        cnt_out_next = SLOT_OUT_W'(MW'(count_next));
    end

    assign wr_fire = exec_done && wr_req;

    // Sequencer: idle (take a request and compare) then execute (write back
    // and load the response register once it is free).
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_done)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec_done)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg    <= req.req_type;
            key_reg     <= key_in;
            idx_reg     <= req.slot_index;
            rd_val_reg  <= rd_sel;
            top_val_reg <= top_sel;
        end
        if (exec_done)
        begin
            status_reg  <= status_next;
            hit_reg     <= hit_next;
            slot_reg    <= slot_next;
            cnt_out_reg <= cnt_out_next;
            value_reg   <= value_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.found_slot  = slot_reg;
    assign rsp.entry_count = cnt_out_reg;
    assign rsp.entry_value = value_reg;

    // The count never passes the capacity.
    `DUSR_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "count exceeds capacity")
    // Uniqueness of keys means at most one live slot can match.
    `DUSR_ASSERT(a_single_match, (state_reg == S_EXEC) |-> $onehot0(hit_vec), "multiple slots match")
    // The count moves only when a request completes.
    `DUSR_ASSERT_NEXT(a_count_hold, !exec_done, $stable(count_reg), "count changed while not completing")
    // An accepted request always enters the execute step.
    `DUSR_ASSERT_NEXT(a_accept_exec, accept, state_reg == S_EXEC, "accepted request not executed")

endmodule

// ----- rtl/core/dusr_cell.sv -----
// One slot of the set: holds a key, compares it against the search key.
// Depends on dusr_pkg for the control struct.
module dusr_cell import dusr_pkg::*; #(
    parameter int KEY_WIDTH = 32,
    parameter int CNT_W     = 6,
    parameter int INDEX     = 0
) (
    input  logic                 clk,
    input  cell_ctl_t            ctl,
    input  logic [CNT_W-1:0]     count,
    input  logic [KEY_WIDTH-1:0] cmp_key,
    input  logic [KEY_WIDTH-1:0] wr_data,
    output logic [KEY_WIDTH-1:0] entry,
    output logic                 match
);

    logic [KEY_WIDTH-1:0] entry_reg;
    logic                 match_reg;
    logic                 active;

    // A slot takes part in a search only while it lies below the count.
    assign active = (CNT_W'(INDEX) < count);

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            entry_reg <= wr_data;
        end
        if (ctl.cmp_en)
        begin
            match_reg <= active && (entry_reg == cmp_key);
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the dense unique set with swap-remove.
// Depends on dusr_pkg, the dusr_req_if / dusr_rsp_if interfaces and the top level.

module tb;
    import dusr_pkg::*;

    // The block is built with its default sizes: 32 slots of 32-bit keys.
    localparam int SET_DEPTH       = 32;
    localparam int RANDOM_ITEMS    = 1950;
    localparam int KEY_POOL_SIZE   = 40;
    localparam int POOL_IDX_W      = $clog2(KEY_POOL_SIZE);
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_AT     = 700;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 8;

    // Request codes the block does not define; they must act as no-ops.
    localparam logic [TYPE_W-1:0] REQ_SPARE_A = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_SPARE_B = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_SPARE_C = 3'd7;

    // Each random segment leans toward one kind of traffic.
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} op_mix_t;

    typedef struct {
        logic [STATUS_W-1:0]   status;
        logic                  hit;
        logic [SLOT_OUT_W-1:0] found_slot;
        logic [SLOT_OUT_W-1:0] entry_count;
        logic [VALUE_W-1:0]    entry_value;
    } set_reply_t;

    typedef struct {
        logic [TYPE_W-1:0]   req_type;
        logic [KEY_IN_W-1:0] key;
        logic [IDX_W-1:0]    slot_index;
        bit                  typed;
        set_reply_t          reply;
    } stim_row_t;

    logic clk;
    logic rst_n;

    dusr_req_if req_ch ();
    dusr_rsp_if rsp_ch ();

    dense_unique_set_swap_remove #(
        .CAPACITY  (SET_DEPTH),
        .KEY_WIDTH (KEY_IN_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the set. Slots at and above shadow_count hold stale data
    // that the block is free to keep; only slots below the count are ever read.
    logic [KEY_IN_W-1:0]   shadow_keys [SET_DEPTH];
    logic [SLOT_OUT_W-1:0] shadow_count;

    // Replies owed by the block, oldest first.
    set_reply_t replies_due[$];

    stim_row_t directed_rows[$];
    logic [KEY_IN_W-1:0] key_pool [KEY_POOL_SIZE];

    int mismatches      = 0;
    int requests_sent   = 0;
    int replies_checked = 0;
    int full_refusals   = 0;
    int peak_count      = 0;
    int cycles          = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Lowest slot below the count that holds k, or the count on a miss.
    function automatic logic [SLOT_OUT_W-1:0] lookup_key(logic [KEY_IN_W-1:0] k);
        for (int i = 0; i < SET_DEPTH; i++)
        begin
            if (i < shadow_count && shadow_keys[i] == k)
                return SLOT_OUT_W'(i);
        end
        return shadow_count;
    endfunction

    // Swap-remove: the top entry fills the hole, then the count drops.
    function automatic void drop_slot(logic [SLOT_OUT_W-1:0] s);
        logic [SLOT_OUT_W-1:0] top;
        top = shadow_count - 1'b1;
        if (s != top)
            shadow_keys[s[IDX_W-1:0]] = shadow_keys[top[IDX_W-1:0]];
        shadow_count = top;
    endfunction

    // Applies one request to the shadow set and returns the reply it earns.
    function automatic set_reply_t apply_set_request(logic [TYPE_W-1:0] kind,
                                                     logic [KEY_IN_W-1:0] k,
                                                     logic [IDX_W-1:0] idx);
        set_reply_t r;
        logic [SLOT_OUT_W-1:0] pos;
        r.status      = ST_OK;
        r.hit         = 1'b0;
        r.found_slot  = shadow_count;
        r.entry_value = '0;
        pos = lookup_key(k);
        case (kind)
            REQ_INSERT:
            begin
                if (pos < shadow_count)
                begin
                    r.status     = ST_PRESENT;
                    r.hit        = 1'b1;
                    r.found_slot = pos;
                end
                else if (shadow_count >= SET_DEPTH)
                begin
                    r.status = ST_FULL;
                    full_refusals++;
                end
                else
                begin
                    shadow_keys[shadow_count[IDX_W-1:0]] = k;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            REQ_ERASE_KEY:
            begin
                if (pos < shadow_count)
                begin
                    r.hit        = 1'b1;
                    r.found_slot = pos;
                    drop_slot(pos);
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            REQ_ERASE_IDX:
            begin
                if (idx < shadow_count)
                begin
                    r.found_slot = SLOT_OUT_W'(idx);
                    drop_slot(SLOT_OUT_W'(idx));
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            REQ_FIND:
            begin
                r.found_slot = pos;
                if (pos < shadow_count)
                    r.hit = 1'b1;
                else
                    r.status = ST_NOT_FOUND;
            end
            REQ_READ:
            begin
                if (idx < shadow_count)
                begin
                    r.found_slot  = SLOT_OUT_W'(idx);
                    r.entry_value = shadow_keys[idx];
                end
                else
                    r.status = ST_RANGE;
            end
            default:
            begin
            end
        endcase
        r.entry_count = shadow_count;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        return r;
    endfunction

    function automatic stim_row_t plain_row(logic [TYPE_W-1:0] kind,
                                            logic [KEY_IN_W-1:0] k,
                                            logic [IDX_W-1:0] idx);
        stim_row_t row;
        row.req_type   = kind;
        row.key        = k;
        row.slot_index = idx;
        row.typed      = 1'b0;
        row.reply      = '{default: '0};
        return row;
    endfunction

    function automatic stim_row_t typed_row(logic [TYPE_W-1:0] kind,
                                            logic [KEY_IN_W-1:0] k,
                                            logic [IDX_W-1:0] idx,
                                            logic [STATUS_W-1:0] st,
                                            logic h,
                                            int slot,
                                            int cnt,
                                            logic [VALUE_W-1:0] val);
        stim_row_t row;
        row = plain_row(kind, k, idx);
        row.typed = 1'b1;
        row.reply = '{st, h, SLOT_OUT_W'(slot), SLOT_OUT_W'(cnt), val};
        return row;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic logic [TYPE_W-1:0] pick_kind(op_mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                if (roll < 85)      return REQ_INSERT;
                else if (roll < 90) return REQ_FIND;
                else if (roll < 95) return REQ_READ;
                else if (roll < 98) return REQ_ERASE_KEY;
                else if (roll < 99) return REQ_ERASE_IDX;
                else                return TYPE_W'($urandom_range(5, 7));
            end
            MIX_DRAIN:
            begin
                if (roll < 40)      return REQ_ERASE_KEY;
                else if (roll < 75) return REQ_ERASE_IDX;
                else if (roll < 85) return REQ_FIND;
                else if (roll < 95) return REQ_READ;
                else                return REQ_INSERT;
            end
            default:
            begin
                if (roll < 30)      return REQ_INSERT;
                else if (roll < 45) return REQ_ERASE_KEY;
                else if (roll < 60) return REQ_ERASE_IDX;
                else if (roll < 80) return REQ_FIND;
                else if (roll < 97) return REQ_READ;
                else                return TYPE_W'($urandom_range(5, 7));
            end
        endcase
    endfunction

    // Offers one request, after a random idle gap unless the sender is quiet, and waits for the transaction.
    // The reply is predicted at acceptance, so the shadow set always matches
    // what the block has taken in. A typed row supplies its own expectation.
    bit sender_quiet = 1'b0;

    task automatic send_request(stim_row_t row);
        int gap;
        set_reply_t predicted;
        if (requests_sent % 64 == 0)
            sender_quiet = ($urandom_range(0, 3) == 0);
        gap = sender_quiet ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= row.req_type;
        req_ch.key        <= row.key;
        req_ch.slot_index <= row.slot_index;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = apply_set_request(row.req_type, row.key, row.slot_index);
        replies_due.insert(replies_due.size(), row.typed ? row.reply : predicted);
        requests_sent++;
    endtask

    // Cycle limit, counted from the start of the run.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d replies outstanding.",
                 cycles, replies_due.size());
        $display("dense_unique_set_swap_remove test failed");
        $finish;
    end

    // Response side: random stalls per reply, quiet stretches without any,
    // and one long hold-off so the block backs up into the request channel.
    initial
    begin : reply_checker
        int stall;
        bit quiet;
        set_reply_t want;
        quiet = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (replies_checked == HOLD_OFF_AT)
                stall = HOLD_OFF_CYCLES;
            else
                stall = quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            replies_checked++;
            if (replies_checked % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (replies_due.size() == 0)
            begin
                $error("reply transaction arrived with none outstanding");
                mismatches++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, rsp_ch.hit);
                    mismatches++;
                end
                if (rsp_ch.found_slot !== want.found_slot)
                begin
                    $error("found_slot: expected %0d, got %0d",
                           want.found_slot, rsp_ch.found_slot);
                    mismatches++;
                end
                if (rsp_ch.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, rsp_ch.entry_count);
                    mismatches++;
                end
                if (rsp_ch.entry_value !== want.entry_value)
                begin
                    $error("entry_value: expected %h, got %h",
                           want.entry_value, rsp_ch.entry_value);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then segments of random traffic.
    initial
    begin : stimulus
        op_mix_t mix;
        int segment_left;
        stim_row_t row;

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_INSERT;
        req_ch.key        <= '0;
        req_ch.slot_index <= '0;
        shadow_count = '0;
        for (int i = 0; i < SET_DEPTH; i++)
            shadow_keys[i] = '0;

        // Empty set: every lookup misses and every index is out of range.
        add_row(typed_row(REQ_READ, 32'h0, 5'd0, ST_RANGE, 1'b0, 0, 0, 0));
        add_row(typed_row(REQ_FIND, 32'h0, 5'd0, ST_NOT_FOUND, 1'b0, 0, 0, 0));
        add_row(typed_row(REQ_ERASE_KEY, 32'hFFFF_FFFF, 5'd31,
                          ST_NOT_FOUND, 1'b0, 0, 0, 0));
        add_row(typed_row(REQ_ERASE_IDX, 32'h0, 5'd0,
                          ST_NOT_FOUND, 1'b0, 0, 0, 0));
        // Extreme keys, then a duplicate insert.
        add_row(typed_row(REQ_INSERT, 32'h0, 5'd0, ST_OK, 1'b0, 0, 1, 0));
        add_row(typed_row(REQ_INSERT, 32'hFFFF_FFFF, 5'd31,
                          ST_OK, 1'b0, 1, 2, 0));
        add_row(typed_row(REQ_INSERT, 32'h0, 5'd0, ST_PRESENT, 1'b1, 0, 2, 0));
        add_row(typed_row(REQ_FIND, 32'hFFFF_FFFF, 5'd0, ST_OK, 1'b1, 1, 2, 0));
        add_row(typed_row(REQ_READ, 32'h0, 5'd1,
                          ST_OK, 1'b0, 1, 2, 32'hFFFF_FFFF));
        // Indexes past the count, and the undefined request codes.
        add_row(typed_row(REQ_READ, 32'h0, 5'd31, ST_RANGE, 1'b0, 2, 2, 0));
        add_row(typed_row(REQ_ERASE_IDX, 32'h0, 5'd31,
                          ST_NOT_FOUND, 1'b0, 2, 2, 0));
        add_row(typed_row(REQ_SPARE_A, 32'hFFFF_FFFF, 5'd31,
                          ST_OK, 1'b0, 2, 2, 0));
        add_row(typed_row(REQ_SPARE_B, 32'hFFFF_FFFF, 5'd0,
                          ST_OK, 1'b0, 2, 2, 0));
        add_row(typed_row(REQ_SPARE_C, 32'h0, 5'd31, ST_OK, 1'b0, 2, 2, 0));
        // Swap-remove from the middle, then from the top slot.
        add_row(plain_row(REQ_INSERT, 32'h8000_0001, 5'd0));
        add_row(plain_row(REQ_INSERT, 32'h7FFF_FFFE, 5'd0));
        add_row(plain_row(REQ_FIND, 32'h7FFF_FFFE, 5'd0));
        add_row(typed_row(REQ_ERASE_KEY, 32'h0, 5'd0, ST_OK, 1'b1, 0, 3, 0));
        add_row(plain_row(REQ_READ, 32'h0, 5'd0));
        add_row(plain_row(REQ_ERASE_IDX, 32'h0, 5'd2));
        add_row(plain_row(REQ_ERASE_KEY, 32'hFFFF_FFFF, 5'd0));
        add_row(plain_row(REQ_READ, 32'h0, 5'd0));
        add_row(plain_row(REQ_FIND, 32'h8000_0001, 5'd0));
        add_row(plain_row(REQ_ERASE_IDX, 32'h0, 5'd0));
        add_row(plain_row(REQ_READ, 32'h0, 5'd0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        // A small key pool keeps hits frequent; being larger than the set,
        // it still lets fill segments run the set up to full.
        foreach (key_pool[i])
            key_pool[i] = $urandom();
        segment_left = 0;
        mix = MIX_BLEND;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (segment_left == 0)
            begin
                segment_left = $urandom_range(60, 200);
                mix = op_mix_t'($urandom_range(0, 2));
                if ($urandom_range(0, 2) == 0)
                    foreach (key_pool[i])
                        key_pool[i] = $urandom();
            end
            segment_left--;
            row.req_type = pick_kind(mix);
            row.typed    = 1'b0;
            row.reply    = '{default: '0};
            if ($urandom_range(0, 9) == 0)
                row.key = $urandom();
            else
                row.key = key_pool[POOL_IDX_W'($urandom_range(0, KEY_POOL_SIZE - 1))];
            if (shadow_count > 0 && $urandom_range(0, 9) < 7)
                row.slot_index = IDX_W'($urandom_range(0, shadow_count - 1));
            else
                row.slot_index = IDX_W'($urandom_range(0, SET_DEPTH - 1));
            send_request(row);
        end
        @(negedge clk);
        req_ch.valid <= 1'b0;

        // The watchdog covers a block that never drains.
        wait (replies_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            $error("%0d replies still outstanding at the end", replies_due.size());
            mismatches++;
        end

        $display("Sent %0d requests (%0d from the directed table) and checked %0d replies.",
                 requests_sent, directed_rows.size(), replies_checked);
        $display("Set peaked at %0d entries; %0d inserts were refused as full.",
                 peak_count, full_refusals);
        if (mismatches == 0)
            $display("dense_unique_set_swap_remove test passed");
        else
            $display("dense_unique_set_swap_remove test failed");
        $finish;
    end

endmodule
